// ===== sv/utf8s_pkg.sv =====
// types, constants and byte-rule functions shared by the utf8 sanitizer
package utf8s_pkg;

    localparam int MaxOut = 10;
    localparam int CntW = $clog2(MaxOut + 1);

    localparam logic [7:0] ByteTab      = 8'd9;
    localparam logic [7:0] ByteLf       = 8'd10;
    localparam logic [7:0] ByteCr       = 8'd13;
    localparam logic [7:0] ByteSpace    = 8'd32;
    localparam logic [7:0] ByteDel      = 8'd127;
    localparam logic [7:0] ByteEuroSrc  = 8'd128;
    localparam logic [7:0] ByteNelSrc   = 8'd133;
    localparam logic [7:0] ByteNbsp     = 8'd160;
    localparam logic [7:0] ByteHigh     = 8'd192;
    localparam logic [7:0] LeadTwoMin   = 8'd194;
    localparam logic [7:0] LeadThreeMin = 8'd224;
    localparam logic [7:0] LeadFourMin  = 8'd240;
    localparam logic [7:0] LeadFourMax  = 8'd244;
    localparam logic [7:0] EuroB0       = 8'd226;
    localparam logic [7:0] EuroB1       = 8'd130;
    localparam logic [7:0] EuroB2       = 8'd172;
    localparam logic [7:0] PrefixC2     = 8'd194;
    localparam logic [7:0] PrefixC3     = 8'd195;
    localparam logic [7:0] Latin1Offset = 8'd64;

    typedef struct packed {
        logic [1:0]      n;
        logic [2:0][7:0] b;
    } seg_t;

    typedef struct packed {
        logic [CntW-1:0]        cnt;
        logic [MaxOut-1:0][7:0] data;
    } result_t;

    function automatic seg_t raw_seg(input logic [7:0] x);
        seg_t s;
        s = '0;
        s.n = 2'd1;
        s.b[0] = x;
        return s;
    endfunction

    // single-byte rules for lone bytes
    function automatic seg_t lone_seg(input logic [7:0] x);
        seg_t s;
        s = '0;
        priority if (x < ByteSpace)
        begin
            if (x == ByteTab || x == ByteLf || x == ByteCr)
            begin
                s.n = 2'd1;
                s.b[0] = x;
            end
        end
        else if (x < ByteDel)
        begin
            s.n = 2'd1;
            s.b[0] = x;
        end
        else if (x < ByteNbsp)
        begin
            if (x == ByteEuroSrc)
            begin
                s.n = 2'd3;
                s.b[0] = EuroB0;
                s.b[1] = EuroB1;
                s.b[2] = EuroB2;
            end
            else if (x == ByteNelSrc)
            begin
                s.n = 2'd2;
                s.b[0] = ByteLf;
                s.b[1] = ByteCr;
            end
        end
        else if (x < ByteHigh)
        begin
            s.n = 2'd2;
            s.b[0] = PrefixC2;
            s.b[1] = x;
        end
        else
        begin
            s.n = 2'd2;
            s.b[0] = PrefixC3;
            s.b[1] = x - Latin1Offset;
        end
        return s;
    endfunction

    // append a segment, dropping bytes beyond the result capacity
    function automatic result_t append_seg(input result_t r, input seg_t s);
        result_t o;
        o = r;
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < s.n && o.cnt < CntW'(MaxOut))
            begin
                o.data[o.cnt] = s.b[k];
                o.cnt = o.cnt + CntW'(1);
            end
        end
        return o;
    endfunction

endpackage

// ===== sv/utf8_stream_sanitizer_top.sv =====
// utf8 stream sanitizer: cleans a raw text byte stream into valid utf-8
// Raw text bytes enter on the slave stream with tlast on the final byte; cleaned
// UTF-8 bytes leave on the master stream, tlast marking the last byte produced by
// each input byte (an input that produces no bytes produces no transfer). One
// input byte is taken per cycle as long as each produces at most one output byte
// and the receiver is ready; an input producing n bytes (up to 10) holds the
// single-byte output port until all n are transferred, and the next input's
// result waits behind it in the input register, where each byte is held before
// its result moves to the output buffer. There is no clearing pass after reset.
module utf8_stream_sanitizer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast    // run_end
);
    import utf8s_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    logic       out_free;
    result_t    res;

    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    utf8s_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .res     (res)
    );

    utf8s_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !s_tready) |-> m_tvalid)
        else $error("input stalled with output buffer empty");

    run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("output run cut short");

    load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!m_tvalid || (m_tready && m_tlast)))
        else $error("result list loaded over pending bytes");

endmodule

// ===== sv/utf8s_core.sv =====
// sequence state and per-byte result list for the utf8 sanitizer
module utf8s_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output utf8s_pkg::result_t  res
);
    import utf8s_pkg::*;

    logic [7:0] lead_reg, lead_next;
    logic [1:0] exp_reg, exp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] cbuf_reg [2];
    logic       cbuf_we;
    logic       is_cont;
    logic       seq_done;
    logic       fresh;

    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign seq_done = ({1'b0, cnt_reg} + 3'd1) >= {1'b0, exp_reg};

    always_comb
    begin
        res       = '0;
        lead_next = lead_reg;
        exp_next  = exp_reg;
        cnt_next  = cnt_reg;
        cbuf_we   = 1'b0;
        fresh     = 1'b0;
        if (exp_reg != 2'd0)
        begin
            if (is_cont)
            begin
                if (seq_done)
                begin
                    if (!(exp_reg == 2'd1 && lead_reg == LeadTwoMin && in_byte < ByteNbsp))
                    begin
                        res = append_seg(res, raw_seg(lead_reg));
                        if (cnt_reg > 2'd0)
                            res = append_seg(res, raw_seg(cbuf_reg[0]));
                        if (cnt_reg > 2'd1)
                            res = append_seg(res, raw_seg(cbuf_reg[1]));
                        res = append_seg(res, raw_seg(in_byte));
                    end
                    exp_next = 2'd0;
                    cnt_next = 2'd0;
                end
                else
                begin
                    cbuf_we  = 1'b1;
                    cnt_next = cnt_reg + 2'd1;
                    if (in_last)
                    begin
                        res = append_seg(res, lone_seg(lead_reg));
                        if (cnt_reg > 2'd0)
                            res = append_seg(res, lone_seg(cbuf_reg[0]));
                        res = append_seg(res, lone_seg(in_byte));
                        exp_next = 2'd0;
                        cnt_next = 2'd0;
                    end
                end
            end
            else
            begin
                res = append_seg(res, lone_seg(lead_reg));
                if (cnt_reg > 2'd0)
                    res = append_seg(res, lone_seg(cbuf_reg[0]));
                if (cnt_reg > 2'd1)
                    res = append_seg(res, lone_seg(cbuf_reg[1]));
                exp_next = 2'd0;
                cnt_next = 2'd0;
                fresh    = 1'b1;
            end
        end
        else
        begin
            fresh = 1'b1;
        end

        if (fresh)
        begin
            if (in_byte >= LeadTwoMin && in_byte <= LeadFourMax && !in_last)
            begin
                lead_next = in_byte;
                cnt_next  = 2'd0;
                priority if (in_byte < LeadThreeMin)
                    exp_next = 2'd1;
                else if (in_byte < LeadFourMin)
                    exp_next = 2'd2;
                else
                    exp_next = 2'd3;
            end
            else
            begin
                res = append_seg(res, lone_seg(in_byte));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= '0;
            exp_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (advance)
        begin
            lead_reg <= lead_next;
            exp_reg  <= exp_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && cbuf_we)
            cbuf_reg[cnt_reg[0]] <= in_byte;
    end

endmodule

// ===== sv/utf8s_top_doc_placeholder.sv =====
// output byte buffer that drains one result list a transfer at a time
module utf8s_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  utf8s_pkg::result_t  res,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);
    import utf8s_pkg::*;

    logic [MaxOut-1:0][7:0] data_reg;
    logic [CntW-1:0]        cnt_reg;
    logic [CntW-1:0]        idx_reg;
    logic                   xfer;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = data_reg[idx_reg];
    assign m_tlast  = (idx_reg == cnt_reg - CntW'(1));
    assign xfer     = m_tvalid && m_tready;
    assign free     = !m_tvalid || (xfer && m_tlast);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= res.cnt;
            idx_reg <= '0;
        end
        else if (xfer && m_tlast)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (xfer)
        begin
            idx_reg <= idx_reg + CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res.data;
    end

endmodule

// ===== bench/utf8_stream_sanitizer_checker.sv =====
// checker for the utf8 stream sanitizer: predicts output bytes and compares transfers
`timescale 1ns / 1ps

module utf8_stream_sanitizer_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,   // in_last
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // out_byte[7:0]
    input  logic       m_tlast,   // run_end
    output int         fail_count,
    output int         pending
);
    import utf8s_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
    } clean_beat_t;

    clean_beat_t clean_bytes_q[$];
    logic [7:0]  run_bytes[$];

    logic [7:0] open_lead;
    logic [1:0] conts_needed;
    logic [7:0] held_conts[2];
    logic [1:0] held_count;

    task automatic emit(input logic [7:0] b);
        if (run_bytes.size() < MaxOut)
            run_bytes = {run_bytes, b};
    endtask

    task automatic emit_lone(input logic [7:0] b);
        if (b < ByteSpace)
        begin
            if (b == ByteTab || b == ByteLf || b == ByteCr)
                emit(b);
        end
        else if (b < ByteDel)
        begin
            emit(b);
        end
        else if (b < ByteNbsp)
        begin
            if (b == ByteEuroSrc)
            begin
                emit(EuroB0);
                emit(EuroB1);
                emit(EuroB2);
            end
            else if (b == ByteNelSrc)
            begin
                emit(ByteLf);
                emit(ByteCr);
            end
        end
        else if (b < ByteHigh)
        begin
            emit(PrefixC2);
            emit(b);
        end
        else
        begin
            emit(PrefixC3);
            emit(b - Latin1Offset);
        end
    endtask

    // broken or unfinished sequence: lead as latin-1, then each held byte alone
    task automatic flush_sequence();
        emit_lone(open_lead);
        for (int k = 0; k < held_count && k < 2; k++)
            emit_lone(held_conts[k]);
        conts_needed = 2'd0;
        held_count = 2'd0;
    endtask

    task automatic start_byte(input logic [7:0] b, input logic is_last);
        if (b >= LeadTwoMin && b <= LeadFourMax && !is_last)
        begin
            open_lead = b;
            conts_needed = (b < LeadThreeMin) ? 2'd1 : ((b < LeadFourMin) ? 2'd2 : 2'd3);
            held_count = 2'd0;
        end
        else
        begin
            emit_lone(b);
        end
    endtask

    task automatic predict_clean(input logic [7:0] b, input logic is_last);
        clean_beat_t beat;
        run_bytes.delete();
        if (conts_needed != 2'd0)
        begin
            if (b >= ByteEuroSrc && b < ByteHigh)
            begin
                if (held_count + 2'd1 >= conts_needed)
                begin
                    if (!(conts_needed == 2'd1 && open_lead == PrefixC2 && b < ByteNbsp))
                    begin
                        emit(open_lead);
                        for (int k = 0; k < held_count && k < 2; k++)
                            emit(held_conts[k]);
                        emit(b);
                    end
                    conts_needed = 2'd0;
                    held_count = 2'd0;
                end
                else
                begin
                    held_conts[held_count[0]] = b;
                    held_count = held_count + 2'd1;
                    if (is_last)
                        flush_sequence();
                end
            end
            else
            begin
                flush_sequence();
                start_byte(b, is_last);
            end
        end
        else
        begin
            start_byte(b, is_last);
        end
        for (int k = 0; k < run_bytes.size(); k++)
        begin
            beat.data = run_bytes[k];
            beat.run_end = (k == run_bytes.size() - 1);
            clean_bytes_q = {clean_bytes_q, beat};
        end
    endtask

    always @(posedge clk)
    begin
        clean_beat_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            clean_bytes_q.delete();
            open_lead = 8'd0;
            conts_needed = 2'd0;
            held_count = 2'd0;
            held_conts[0] = 8'd0;
            held_conts[1] = 8'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_clean(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (clean_bytes_q.size() == 0)
                begin
                    $display("%0t: unexpected output transfer data=%02h last=%0b",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = clean_bytes_q.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.run_end)
                    begin
                        $display("%0t: mismatch expected data=%02h last=%0b %s%02h last=%0b",
                                 $time, want.data, want.run_end, "actual data=",
                                 m_tdata, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending = clean_bytes_q.size();
    end

endmodule

// ===== bench/tb.sv =====
// testbench top for the utf8 stream sanitizer: stimulus, backpressure and verdict
`timescale 1ns / 1ps

module tb;

    localparam int CycleLimit = 300000;
    localparam int LongHoldCycles = 300;
    localparam int DrainCycles = 40;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int   fail_count;
    int   pending;
    int   cycle_count;
    int   items_sent;
    int   send_gap_pct;
    int   recv_idle_pct;
    logic long_hold_req = 1'b0;

    utf8_stream_sanitizer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    utf8_stream_sanitizer_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // receiver side, with a single long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                for (int k = 0; k < LongHoldCycles; k++)
                    @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic offer_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic offer_text_byte(input logic [7:0] b);
        offer_byte(b, $urandom_range(15) == 0);
    endtask

    task automatic offer_cont();
        offer_text_byte(8'($urandom_range(128, 191)));
    endtask

    // one random piece of text: mostly well-formed sequences, some noise and breaks
    task automatic offer_random_piece();
        int kind;
        int need;
        int given;
        logic [7:0] lead;
        kind = $urandom_range(99);
        if (kind < 18)
        begin
            offer_text_byte(8'($urandom_range(255)));
        end
        else if (kind < 32)
        begin
            if ($urandom_range(3) == 0)
                offer_text_byte(8'($urandom_range(0, 31)));
            else
                offer_text_byte(8'($urandom_range(32, 126)));
        end
        else if (kind < 48)
        begin
            offer_text_byte(8'($urandom_range(194, 223)));
            offer_cont();
        end
        else if (kind < 63)
        begin
            offer_text_byte(8'($urandom_range(224, 239)));
            offer_cont();
            offer_cont();
        end
        else if (kind < 76)
        begin
            offer_text_byte(8'($urandom_range(240, 244)));
            offer_cont();
            offer_cont();
            offer_cont();
        end
        else if (kind < 84)
        begin
            offer_text_byte(8'd194);
            offer_text_byte(8'($urandom_range(128, 159)));
        end
        else
        begin
            lead = 8'($urandom_range(194, 244));
            need = (lead < 224) ? 1 : ((lead < 240) ? 2 : 3);
            given = $urandom_range(need - 1);
            offer_text_byte(lead);
            for (int k = 0; k < given; k++)
                offer_cont();
            if ($urandom_range(1) == 0)
                offer_text_byte(8'($urandom_range(0, 127)));
            else
                offer_text_byte(8'($urandom_range(192, 255)));
        end
    endtask

    initial
    begin
        logic [7:0] directed_bytes[25];
        directed_bytes = '{8'h00, 8'h09, 8'h7f, 8'h80, 8'h85, 8'hc0, 8'hff,
                           8'hc3, 8'ha9, 8'hc2, 8'h85, 8'he2, 8'h82, 8'hac,
                           8'hf0, 8'h80, 8'h80, 8'hff, 8'he0, 8'he1, 8'h80,
                           8'hf4, 8'h8f, 8'hbf, 8'hbf};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        items_sent = 0;
        send_gap_pct = 17;
        recv_idle_pct = 78;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // lead with end of text, unfinished sequence at end of text,
        // complete four-byte sequence ending the text
        for (int k = 0; k < 25; k++)
            offer_byte(directed_bytes[k], k == 18 || k == 20 || k == 24);
        while (items_sent < 125)
            offer_random_piece();

        send_gap_pct = 78;
        recv_idle_pct = 17;
        while (items_sent < 225)
            offer_random_piece();

        send_gap_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b1;
        while (items_sent < 325)
            offer_random_piece();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
